// ===== hdl/rmq_pkg.sv =====
// Shared types, widths and helpers for the rotation-matrix-to-quaternion block.
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

    localparam int FRAC_BITS = 14;

    // Square-root argument, signed: ONE plus three 16-bit terms
    localparam int ARG_W  = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 3;
    // Radicand is the non-negative argument scaled by ONE
    localparam int RAD_W  = ARG_W - 1 + FRAC_BITS;
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int RAD2_W = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    // Sums and differences of two elements, and their magnitude
    localparam int D_W    = 18;
    localparam int MAG_W  = 17;
    // Dividend magnitude: |d| * 2^(FRAC_BITS-1)
    localparam int NUM_W  = MAG_W + FRAC_BITS - 1;

    localparam logic signed [ARG_W-1:0] ONE_A = ARG_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } t_branch;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_in;

    typedef struct packed {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        t_branch            branch_used;
        logic               degenerate;
    } t_out;

    // Square-root stage: digit-by-digit root, two radicand bits per stage
    typedef struct packed {
        logic                    vld;
        t_branch                 branch;
        logic                    degen;
        logic [2:0][D_W-1:0]     num;
        logic [RAD2_W-1:0]       rad;
        logic [REM_W-1:0]        rem;
        logic [ROOT_W-1:0]       root;
    } t_sq;

    // Divider stage: three restoring lanes sharing one divisor
    typedef struct packed {
        logic                    vld;
        t_branch                 branch;
        logic                    degen;
        logic [ROOT_W-1:0]       root;
        logic [2:0]              neg;
        logic [2:0][NUM_W-1:0]   num;
        logic [2:0][ROOT_W:0]    rem;
    } t_dv;

    function automatic logic signed [15:0] sat16(input logic signed [NUM_W:0] v);
        logic signed [15:0] res;
        if (v > $signed(32'sd32767)) begin
            res = 16'sh7fff;
        end else if (v < $signed(-32'sd32768)) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// Pipelined rotation matrix to quaternion conversion (Shepperd branch selection).
// Stages: one setup stage, one square-root stage per root bit, the divider hand-off register,
//   one divider stage per quotient bit and the output register; elements and components are Q2.14.
// Throughput: one item per cycle; the whole pipeline advances whenever the output
//   register is empty or being taken.
// Reset: synchronous active-low i_rst_n clears every stage valid bit; data is not reset.
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);

    logic en;

    t_sq r_sq [0:ROOT_W];
    t_sq n_sq [1:ROOT_W];
    t_dv r_dv [0:NUM_W];
    t_dv n_dv [1:NUM_W];
    t_sq s_sq0;
    t_dv s_dv0;
    t_out n_out;
    t_out r_out;
    logic r_out_vld;

    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // Setup: pick branch, form argument and the three numerators
    always_comb begin
        logic signed [ARG_W-1:0] at, ax, ay, az, arg;
        logic signed [D_W-1:0]   da, db, dc, sp, sq, sr;
        logic signed [15:0]      best;
        t_branch                 br;
        logic                    dg;
        at = ONE_A + ARG_W'(i_data.m00) + ARG_W'(i_data.m11) + ARG_W'(i_data.m22);
        ax = ONE_A + ARG_W'(i_data.m00) - ARG_W'(i_data.m11) - ARG_W'(i_data.m22);
        ay = ONE_A - ARG_W'(i_data.m00) + ARG_W'(i_data.m11) - ARG_W'(i_data.m22);
        az = ONE_A - ARG_W'(i_data.m00) - ARG_W'(i_data.m11) + ARG_W'(i_data.m22);
        da = D_W'(i_data.m12) - D_W'(i_data.m21);
        db = D_W'(i_data.m20) - D_W'(i_data.m02);
        dc = D_W'(i_data.m01) - D_W'(i_data.m10);
        sp = D_W'(i_data.m10) + D_W'(i_data.m01);
        sq = D_W'(i_data.m20) + D_W'(i_data.m02);
        sr = D_W'(i_data.m21) + D_W'(i_data.m12);
        best = i_data.m00;
        br   = BR_X;
        if (i_data.m11 > best) begin
            best = i_data.m11;
            br   = BR_Y;
        end
        if (i_data.m22 > best) begin
            br = BR_Z;
        end
        if (at > 0) begin
            br = BR_TRACE;
        end
        s_sq0 = '0;
        case (br)
            BR_TRACE: begin
                arg = at;
                s_sq0.num = {dc, db, da};
            end
            BR_X: begin
                arg = ax;
                s_sq0.num = {da, sq, sp};
            end
            BR_Y: begin
                arg = ay;
                s_sq0.num = {db, sr, sp};
            end
            default: begin
                arg = az;
                s_sq0.num = {dc, sr, sq};
            end
        endcase
        dg = (arg <= 0);
        s_sq0.vld    = i_valid;
        s_sq0.branch = br;
        s_sq0.degen  = dg;
        s_sq0.rad    = dg ? '0 : RAD2_W'({arg[ARG_W-2:0], {FRAC_BITS{1'b0}}});
    end

    // Square-root stages
    always_comb begin
        logic [REM_W-1:0] rem2, trial;
        for (int k = 0; k < ROOT_W; k++) begin
            n_sq[k+1] = r_sq[k];
            rem2  = {r_sq[k].rem[REM_W-3:0], r_sq[k].rad[RAD2_W-1 -: 2]};
            trial = REM_W'({r_sq[k].root, 2'b01});
            n_sq[k+1].rad = {r_sq[k].rad[RAD2_W-3:0], 2'b00};
            if (rem2 >= trial) begin
                n_sq[k+1].rem  = rem2 - trial;
                n_sq[k+1].root = {r_sq[k].root[ROOT_W-2:0], 1'b1};
            end else begin
                n_sq[k+1].rem  = rem2;
                n_sq[k+1].root = {r_sq[k].root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Hand off to the divider: magnitudes and signs of the numerators
    always_comb begin
        logic signed [D_W-1:0] d;
        logic [D_W-1:0]        mag;
        s_dv0        = '0;
        s_dv0.vld    = r_sq[ROOT_W].vld;
        s_dv0.branch = r_sq[ROOT_W].branch;
        s_dv0.degen  = r_sq[ROOT_W].degen;
        s_dv0.root   = r_sq[ROOT_W].root;
        for (int l = 0; l < 3; l++) begin
            d   = signed'(r_sq[ROOT_W].num[l]);
            mag = d[D_W-1] ? D_W'(-d) : D_W'(d);
            s_dv0.neg[l] = d[D_W-1];
            s_dv0.num[l] = NUM_W'({mag[MAG_W-1:0], {(FRAC_BITS-1){1'b0}}});
        end
    end

    // Divider stages: one quotient bit per stage in each lane
    always_comb begin
        logic [ROOT_W:0] sh;
        for (int j = 0; j < NUM_W; j++) begin
            n_dv[j+1] = r_dv[j];
            for (int l = 0; l < 3; l++) begin
                sh = {r_dv[j].rem[l][ROOT_W-1:0], r_dv[j].num[l][NUM_W-1]};
                if (sh >= {1'b0, r_dv[j].root}) begin
                    n_dv[j+1].rem[l] = sh - {1'b0, r_dv[j].root};
                    n_dv[j+1].num[l] = {r_dv[j].num[l][NUM_W-2:0], 1'b1};
                end else begin
                    n_dv[j+1].rem[l] = sh;
                    n_dv[j+1].num[l] = {r_dv[j].num[l][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    // Sign, saturate and place the half-root in the branch's own component; zero degenerate items
    always_comb begin
        logic signed [NUM_W:0]       q [0:2];
        logic signed [NUM_W:0]       half;
        logic signed [3:0][15:0]     c;
        for (int l = 0; l < 3; l++) begin
            q[l] = r_dv[NUM_W].neg[l] ? -$signed({1'b0, r_dv[NUM_W].num[l]})
                                      :  $signed({1'b0, r_dv[NUM_W].num[l]});
        end
        half = $signed((NUM_W+1)'(r_dv[NUM_W].root >> 1));
        case (r_dv[NUM_W].branch)
            BR_TRACE: c = {sat16(half), sat16(q[2]), sat16(q[1]), sat16(q[0])};
            BR_X:     c = {sat16(q[2]), sat16(q[1]), sat16(q[0]), sat16(half)};
            BR_Y:     c = {sat16(q[2]), sat16(q[1]), sat16(half), sat16(q[0])};
            default:  c = {sat16(q[2]), sat16(half), sat16(q[1]), sat16(q[0])};
        endcase
        if (r_dv[NUM_W].degen) begin
            c = '0;
        end
        n_out.qx          = c[0];
        n_out.qy          = c[1];
        n_out.qz          = c[2];
        n_out.qw          = c[3];
        n_out.branch_used = r_dv[NUM_W].branch;
        n_out.degenerate  = r_dv[NUM_W].degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ROOT_W; k++) begin
                r_sq[k].vld <= 1'b0;
            end
            for (int j = 0; j <= NUM_W; j++) begin
                r_dv[j].vld <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_sq[0] <= s_sq0;
            for (int k = 1; k <= ROOT_W; k++) begin
                r_sq[k] <= n_sq[k];
            end
            r_dv[0] <= s_dv0;
            for (int j = 1; j <= NUM_W; j++) begin
                r_dv[j] <= n_dv[j];
            end
            r_out     <= n_out;
            r_out_vld <= r_dv[NUM_W].vld;
        end
    end

`ifndef NO_ASSERTIONS
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |->
            o_data.qx == 0 && o_data.qy == 0 && o_data.qz == 0 && o_data.qw == 0)
        else $error("degenerate item with nonzero components");

    a_trace_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.branch_used == BR_TRACE |->
            !o_data.degenerate && !o_data.qw[15])
        else $error("trace branch item degenerate or with negative w");

    a_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_dv[NUM_W].vld) && $stable(r_sq[0].vld))
        else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_rotation_matrix_to_quaternion.sv =====
// Testbench for the rotation-matrix-to-quaternion block: directed rows plus random matrices.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
    import rmq_pkg::*;

    localparam int LATENCY   = 49;
    localparam int WDOG_MAX  = 5000;
    localparam int N_RANDOM  = 1300;
    localparam int N_ROWS    = 20;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    int   send_idle_pct;
    int   recv_idle_pct;
    int   errors;
    int   wdog;
    t_out quat_queue[$];

    rotation_matrix_to_quaternion uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Truncating divide d * 2^(FRAC_BITS-1) / r
    function automatic longint quat_div(input longint d, input longint r);
        longint n;
        n = d * (64'sd1 <<< (FRAC_BITS - 1));
        return n / r;
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    function automatic longint root_floor(input longint v);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 64'd4000000000;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic t_out quat_of_matrix(input t_in m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
        longint one, arg, r, half, best;
        longint q[4];
        t_branch br;
        t_out res;
        a00 = m.m00; a01 = m.m01; a02 = m.m02;
        a10 = m.m10; a11 = m.m11; a12 = m.m12;
        a20 = m.m20; a21 = m.m21; a22 = m.m22;
        one = 64'sd1 <<< FRAC_BITS;
        q = '{0, 0, 0, 0};
        res.degenerate = 1'b0;
        arg = one + a00 + a11 + a22;
        br = BR_TRACE;
        if (arg <= 0) begin
            best = a00;
            br = BR_X;
            if (a11 > best) begin
                best = a11;
                br = BR_Y;
            end
            if (a22 > best) br = BR_Z;
            case (br)
                BR_X: arg = one + a00 - a11 - a22;
                BR_Y: arg = one - a00 + a11 - a22;
                default: arg = one - a00 - a11 + a22;
            endcase
            if (arg <= 0) res.degenerate = 1'b1;
        end
        if (!res.degenerate) begin
            r = root_floor(arg * one);
            half = r >>> 1;
            case (br)
                BR_TRACE: q = '{quat_div(a12 - a21, r), quat_div(a20 - a02, r),
                                quat_div(a01 - a10, r), half};
                BR_X: q = '{half, quat_div(a10 + a01, r), quat_div(a20 + a02, r),
                            quat_div(a12 - a21, r)};
                BR_Y: q = '{quat_div(a10 + a01, r), half, quat_div(a21 + a12, r),
                            quat_div(a20 - a02, r)};
                default: q = '{quat_div(a20 + a02, r), quat_div(a21 + a12, r), half,
                               quat_div(a01 - a10, r)};
            endcase
        end
        res.qx = clip16(q[0]);
        res.qy = clip16(q[1]);
        res.qz = clip16(q[2]);
        res.qw = clip16(q[3]);
        res.branch_used = br;
        return res;
    endfunction

    function automatic logic signed [15:0] rand_elem(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 32767 + 16384) - 16384);
            default: return 16'($urandom_range(0, 4096) - 2048);
        endcase
    endfunction

    // For part of the random matrices, pick a sign pattern for the diagonal
    // so every branch is reached.
    function automatic t_in rand_matrix();
        t_in m;
        int mode;
        int pick;
        mode = $urandom_range(0, 3);
        m.m00 = rand_elem(mode); m.m01 = rand_elem(mode); m.m02 = rand_elem(mode);
        m.m10 = rand_elem(mode); m.m11 = rand_elem(mode); m.m12 = rand_elem(mode);
        m.m20 = rand_elem(mode); m.m21 = rand_elem(mode); m.m22 = rand_elem(mode);
        pick = $urandom_range(0, 5);
        if (mode != 0 && pick < 3) begin
            // set the diagonal negative, then make one diagonal element lead
            m.m00 = -16'sd16384 + 16'($urandom_range(0, 8000)) - 16'sd4000;
            m.m11 = -16'sd16384 + 16'($urandom_range(0, 8000)) - 16'sd4000;
            m.m22 = -16'sd16384 + 16'($urandom_range(0, 8000)) - 16'sd4000;
            case (pick)
                0: m.m00 = 16'($urandom_range(0, 16384));
                1: m.m11 = 16'($urandom_range(0, 16384));
                default: m.m22 = 16'($urandom_range(0, 16384));
            endcase
        end
        return m;
    endfunction

    task automatic send_matrix(input t_in m);
        i_valid <= 1'b1;
        i_data  <= m;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        quat_queue.push_back(quat_of_matrix(m));
        // drop valid only for idle cycles so back-to-back items keep it high
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Receiver: random stall, compare against the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            wdog    <= 0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if ((i_valid && o_ready) || (o_valid && i_ready)) wdog <= 0;
            else wdog <= wdog + 1;
            if (o_valid && i_ready) begin
                if (quat_queue.size() == 0) begin
                    $display("%0t unexpected item: %p", $time, o_data);
                    errors++;
                end else begin
                    want = quat_queue.pop_front();
                    if (o_data.qx !== want.qx || o_data.qy !== want.qy
                            || o_data.qz !== want.qz || o_data.qw !== want.qw
                            || o_data.branch_used !== want.branch_used
                            || o_data.degenerate !== want.degenerate) begin
                        $display("%0t mismatch expected %p actual %p", $time, want, o_data);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (wdog >= WDOG_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    typedef struct {
        t_in  mat;
        logic known;
        t_out want;
    } t_row;

    t_row rows[N_ROWS];

    initial begin
        t_in z;
        t_in m;
        z = '0;
        errors = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_valid = 1'b0;
        i_data  = '0;
        i_ready = 1'b0;
        i_rst_n = 1'b0;
        foreach (rows[k]) begin
            rows[k].mat = z;
            rows[k].known = 1'b0;
            rows[k].want = '0;
        end
        // zero matrix: trace branch, root of ONE, half is ONE/2
        rows[0].known = 1'b1;
        rows[0].want = '{16'sd0, 16'sd0, 16'sd0, 16'sd8192, BR_TRACE, 1'b0};
        // identity
        m = z; m.m00 = 16'sd16384; m.m11 = 16'sd16384; m.m22 = 16'sd16384;
        rows[1].mat = m; rows[1].known = 1'b1;
        rows[1].want = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, BR_TRACE, 1'b0};
        // 180 degrees about x, y, z
        m = z; m.m00 = 16'sd16384; m.m11 = -16'sd16384; m.m22 = -16'sd16384;
        rows[2].mat = m; rows[2].known = 1'b1;
        rows[2].want = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, BR_X, 1'b0};
        m = z; m.m00 = -16'sd16384; m.m11 = 16'sd16384; m.m22 = -16'sd16384;
        rows[3].mat = m; rows[3].known = 1'b1;
        rows[3].want = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, BR_Y, 1'b0};
        m = z; m.m00 = -16'sd16384; m.m11 = -16'sd16384; m.m22 = 16'sd16384;
        rows[4].mat = m; rows[4].known = 1'b1;
        rows[4].want = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, BR_Z, 1'b0};
        // all diagonal at minimum: tie picks x, argument still positive
        m = z; m.m00 = -16'sd32768; m.m11 = -16'sd32768; m.m22 = -16'sd32768;
        rows[5].mat = m;
        // tie between m00 and m11 at -ONE/2 goes to x
        m = z; m.m00 = -16'sd8192; m.m11 = -16'sd8192; m.m22 = -16'sd16384;
        rows[6].mat = m;
        // tie between m11 and m22 with m00 at minimum goes to y
        m = z; m.m00 = -16'sd32768; m.m11 = -16'sd8192; m.m22 = 16'sd32767;
        m.m22 = -16'sd4096; m.m11 = -16'sd4096; m.m00 = -16'sd32768;
        rows[7].mat = m;
        // ties between m11 and m22 go to y
        m = z; m.m00 = -16'sd20000; m.m11 = -16'sd2000; m.m22 = -16'sd2000;
        rows[8].mat = m;
        // z branch leads with m11 at minimum
        m = z; m.m00 = -16'sd3000; m.m11 = -16'sd3000; m.m22 = -16'sd2000;
        m.m00 = 16'sd100; m.m11 = -16'sd32768; m.m22 = 16'sd200;
        rows[9].mat = m;
        // saturation: tiny root, large off-diagonals
        m = z; m.m00 = -16'sd16383; m.m11 = 16'sd0; m.m22 = 16'sd0;
        m.m00 = -16'sd16383; m.m11 = -16'sd1; m.m22 = 16'sd1;
        m.m12 = 16'sd32767; m.m21 = -16'sd32768; m.m01 = -16'sd32768; m.m10 = 16'sd32767;
        m.m20 = 16'sd32767; m.m02 = -16'sd32768;
        rows[10].mat = m;
        m = '1; rows[11].mat = m;
        m = z; m.m01 = 16'sd32767; m.m02 = 16'sd32767; m.m10 = 16'sd32767;
        m.m12 = 16'sd32767; m.m20 = 16'sd32767; m.m21 = 16'sd32767;
        rows[12].mat = m;
        m = z; m.m01 = -16'sd32768; m.m02 = -16'sd32768; m.m10 = -16'sd32768;
        m.m12 = -16'sd32768; m.m20 = -16'sd32768; m.m21 = -16'sd32768;
        rows[13].mat = m;
        m = z; m.m00 = 16'sd32767; m.m11 = 16'sd32767; m.m22 = 16'sd32767;
        rows[14].mat = m;
        // x branch, trace argument exactly zero (not positive)
        m = z; m.m00 = -16'sd5461; m.m11 = -16'sd5461; m.m22 = -16'sd5462;
        m.m10 = 16'sd32767; m.m01 = 16'sd32767; m.m12 = -16'sd32768; m.m21 = 16'sd32767;
        rows[15].mat = m;
        m = z; m.m00 = -16'sd32768; m.m11 = -16'sd32768; m.m22 = 16'sd32767;
        m.m20 = 16'sd32767; m.m02 = 16'sd32767; m.m01 = -16'sd32768; m.m10 = 16'sd32767;
        rows[16].mat = m;
        m = z; m.m00 = -16'sd32768; m.m11 = 16'sd32767; m.m22 = -16'sd32768;
        m.m21 = -16'sd32768; m.m12 = -16'sd32768; m.m20 = -16'sd32768; m.m02 = 16'sd32767;
        rows[17].mat = m;
        // trace just positive: smallest root
        m = z; m.m00 = -16'sd16383; m.m11 = 16'sd0; m.m22 = 16'sd0;
        m.m12 = 16'sd1; m.m21 = -16'sd1;
        rows[18].mat = m;
        m = z; m.m00 = -16'sd1; m.m11 = -16'sd1; m.m22 = -16'sd1;
        rows[19].mat = m;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].known && quat_of_matrix(rows[k].mat) !== rows[k].want) begin
                $display("%0t table row %0d expected %p actual %p", $time, k,
                         rows[k].want, quat_of_matrix(rows[k].mat));
                errors++;
            end
            send_matrix(rows[k].mat);
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 52 : 0;
            recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 32 : 0;
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                send_matrix(rand_matrix());
            end
        end
        i_valid <= 1'b0;

        while (quat_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
